>>> rtl/core/rmat_pkg.sv
`default_nettype none
package rmat_pkg;
    localparam logic [1:0] OP_TRANSLATE = 2'd0;
    localparam logic [1:0] OP_CLAIM     = 2'd1;
    localparam logic [1:0] OP_MAP       = 2'd2;

    localparam logic [1:0] SRC_MAP      = 2'd0;
    localparam logic [1:0] SRC_IDENTITY = 2'd1;
    localparam logic [1:0] SRC_UNMAPPED = 2'd2;
    localparam logic [1:0] SRC_NONE     = 2'd3;

    localparam logic [2:0] REG_RAM_BASE  = 3'd0;
    localparam logic [2:0] REG_RAM_SIZE  = 3'd1;
    localparam logic [2:0] REG_ROM_BASE  = 3'd2;
    localparam logic [2:0] REG_ROM_SIZE  = 3'd3;
    localparam logic [2:0] REG_SHIM_BASE = 3'd4;

    localparam logic [31:0] IDENTITY_MODE = 32'h12;
    localparam logic [31:0] TOP_CLAMP     = 32'hffffffff;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CHECK,
        ST_DONE,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic decode;
        logic rd_start;
        logic rd_next;
        logic check;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_translate;
        logic scan_empty;
        logic hit;
        logic last;
    } stat_t;

    // clamped exclusive end of [base, base + size)
    function automatic logic [31:0] range_end(input logic [31:0] base, input logic [31:0] size);
        logic [32:0] e;
        e = {1'b0, base} + {1'b0, size};
        return e[32] ? TOP_CLAMP : e[31:0];
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/rmat_ram.sv
`default_nettype none
module rmat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/rmat_ctrl.sv
`default_nettype none
module rmat_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    input  wire rmat_pkg::stat_t st,
    output rmat_pkg::cmd_t      cmd
);
    import rmat_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequencing of one request
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                if (st.is_translate && !st.scan_empty)
                begin
                    cmd.rd_start = 1'b1;
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                if (st.hit || st.last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/core/rmat_dp.sv
`default_nettype none
module rmat_dp #(
    parameter int TABLE_DEPTH = 32,
    parameter int RESERVED_PAGE_BYTES = 4096
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rmat_pkg::cmd_t cmd,
    output rmat_pkg::stat_t     st,
    input  wire logic [1:0]     op,
    input  wire logic [2:0]     arg_count,
    input  wire logic [31:0]    cell0,
    input  wire logic [31:0]    cell1,
    input  wire logic [31:0]    cell2,
    input  wire logic [31:0]    cell3,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    output logic [162:0]        result
);
    import rmat_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [32:0] PAGE = 33'(RESERVED_PAGE_BYTES);

    logic [31:0] ram_base_reg, ram_size_reg, rom_base_reg, rom_size_reg, shim_reg;
    logic [CW-1:0] count_reg;
    logic [31:0] tcnt_reg, mcnt_reg, ccnt_reg;
    logic [1:0]  op_reg;
    logic [31:0] c0_reg, c1_reg, c2_reg, c3_reg;
    logic [CW-1:0] idx_reg;
    logic        found_reg, coll_reg;
    logic [31:0] hphys_reg, hmode_reg;
    logic        status_reg;
    logic [31:0] r1_reg, r2_reg;
    logic [1:0]  src_reg;
    logic        status_next;
    logic [31:0] r1_next, r2_next;
    logic [1:0]  src_next;

    logic [31:0] rd_virt, rd_phys, rd_size, rd_mode;
    logic [AW-1:0] raddr, waddr;
    logic        we;

    // reserved page overlap, size zero taken as one byte
    logic [31:0] chk_base, chk_size, chk_end;
    logic [32:0] page_hi;
    logic        collide;
    always_comb
    begin
        chk_base = (op_reg == OP_MAP) ? c2_reg : c0_reg;
        chk_size = (c1_reg == 32'd0) ? 32'd1 : c1_reg;
        chk_end  = range_end(chk_base, chk_size);
        page_hi  = {1'b0, shim_reg} + PAGE;
        collide  = ({1'b0, chk_base} < page_hi) && (chk_end > shim_reg);
    end

    assign we = cmd.decode && (op_reg == OP_MAP) && !collide
                && (count_reg < CW'(TABLE_DEPTH));
    assign waddr = count_reg[AW-1:0];
    assign raddr = cmd.rd_start ? AW'(count_reg - CW'(1)) : AW'(idx_reg - CW'(1));

    rmat_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_virt (.clk(clk), .we(we), .waddr(waddr),
        .wdata(c2_reg), .raddr(raddr), .rdata(rd_virt));
    rmat_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_phys (.clk(clk), .we(we), .waddr(waddr),
        .wdata(c3_reg), .raddr(raddr), .rdata(rd_phys));
    rmat_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_size (.clk(clk), .we(we), .waddr(waddr),
        .wdata(c1_reg), .raddr(raddr), .rdata(rd_size));
    rmat_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_mode (.clk(clk), .we(we), .waddr(waddr),
        .wdata(c0_reg), .raddr(raddr), .rdata(rd_mode));

    // entry compare on the word just read
    logic entry_hit;
    assign entry_hit = (c0_reg >= rd_virt) && (c0_reg < range_end(rd_virt, rd_size));

    // identity apertures
    logic ident;
    always_comb
    begin
        ident = (ram_size_reg != 32'd0 && c0_reg < ram_size_reg)
             || (ram_size_reg != 32'd0 && c0_reg >= ram_base_reg
                 && c0_reg < range_end(ram_base_reg, ram_size_reg))
             || (rom_size_reg != 32'd0 && c0_reg >= rom_base_reg
                 && c0_reg < range_end(rom_base_reg, rom_size_reg));
    end

    assign st.is_translate = (op_reg == OP_TRANSLATE);
    assign st.scan_empty   = (count_reg == CW'(0));
    assign st.hit          = entry_hit;
    assign st.last         = (idx_reg == CW'(1));

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_base_reg <= '0;
            ram_size_reg <= '0;
            rom_base_reg <= '0;
            rom_size_reg <= '0;
            shim_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RAM_BASE:  ram_base_reg <= cfg_data;
                REG_RAM_SIZE:  ram_size_reg <= cfg_data;
                REG_ROM_BASE:  rom_base_reg <= cfg_data;
                REG_ROM_SIZE:  rom_size_reg <= cfg_data;
                REG_SHIM_BASE: shim_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // counters and table fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tcnt_reg  <= '0;
            mcnt_reg  <= '0;
            ccnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we && (cfg_index == REG_RAM_BASE || cfg_index == REG_RAM_SIZE
                || cfg_index == REG_ROM_BASE || cfg_index == REG_ROM_SIZE))
            begin
                count_reg <= '0;
            end
            else if (we)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.decode)
            begin
                if (op_reg == OP_TRANSLATE)
                begin
                    tcnt_reg <= tcnt_reg + 32'd1;
                end
                if (op_reg == OP_MAP)
                begin
                    mcnt_reg <= mcnt_reg + 32'd1;
                end
                if ((op_reg == OP_MAP || op_reg == OP_CLAIM) && collide)
                begin
                    ccnt_reg <= ccnt_reg + 32'd1;
                end
            end
        end
    end

    // result fields by operation
    always_comb
    begin
        status_next = 1'b0;
        r1_next = 32'd0;
        r2_next = 32'd0;
        src_next = SRC_NONE;
        case (op_reg)
            OP_TRANSLATE:
            begin
                if (found_reg)
                begin
                    r1_next = hphys_reg;
                    r2_next = hmode_reg;
                    src_next = SRC_MAP;
                end
                else if (ident)
                begin
                    r1_next = c0_reg;
                    r2_next = IDENTITY_MODE;
                    src_next = SRC_IDENTITY;
                end
                else
                begin
                    src_next = SRC_UNMAPPED;
                end
            end
            OP_CLAIM:
            begin
                status_next = coll_reg;
                r1_next = coll_reg ? 32'd0 : c0_reg;
            end
            OP_MAP:
            begin
                status_next = coll_reg;
            end
            default: ;
        endcase
    end

    // request capture, scan and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            c0_reg <= (arg_count >= 3'd1) ? cell0 : 32'd0;
            c1_reg <= (arg_count >= 3'd2) ? cell1 : 32'd1;
            c2_reg <= (arg_count >= 3'd3) ? cell2 : 32'd0;
            c3_reg <= (arg_count >= 3'd4) ? cell3 : 32'd0;
        end
        if (cmd.decode)
        begin
            found_reg <= 1'b0;
            coll_reg  <= collide;
            idx_reg   <= count_reg;
        end
        if (cmd.rd_next)
        begin
            idx_reg <= idx_reg - CW'(1);
        end
        if (cmd.check && entry_hit)
        begin
            found_reg <= 1'b1;
            hphys_reg <= rd_phys + (c0_reg - rd_virt);
            hmode_reg <= rd_mode;
        end
        if (cmd.finish)
        begin
            status_reg <= status_next;
            r1_reg <= r1_next;
            r2_reg <= r2_next;
            src_reg <= src_next;
        end
    end

    assign result = {ccnt_reg, mcnt_reg, tcnt_reg, src_reg, r2_reg, r1_reg, status_reg};
endmodule
`default_nettype wire

>>> rtl/core/range_map_address_translator.sv
`default_nettype none
// Range-map address translator. Requests take op, arg_count and four cells; each returns one
// result. Translate scans the recorded maps newest first through a registered-read table,
// stopping at the first hit, then falls back to the identity apertures. A new request is taken
// only after the result of the last one has been accepted.
// Configuration registers 0..3 clear the map table; write them only while the block is idle.
module range_map_address_translator #(
    parameter int TABLE_DEPTH = 32,
    parameter int RESERVED_PAGE_BYTES = 4096
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op[1:0], arg_count[4:2], cell0[36:5], cell1[68:37], cell2[100:69], cell3[132:101]
    input  wire logic [135:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // status[0], result_cell1[32:1], result_cell2[64:33], translate_source[66:65],
    // translate_total[98:67], map_total[130:99], collision_total[162:131]
    output logic [167:0]      m_axis_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    import rmat_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic [162:0] res;

    rmat_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .st(st), .cmd(cmd)
    );

    rmat_dp #(.TABLE_DEPTH(TABLE_DEPTH), .RESERVED_PAGE_BYTES(RESERVED_PAGE_BYTES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .st(st),
        .op(s_axis_tdata[1:0]), .arg_count(s_axis_tdata[4:2]),
        .cell0(s_axis_tdata[36:5]), .cell1(s_axis_tdata[68:37]),
        .cell2(s_axis_tdata[100:69]), .cell3(s_axis_tdata[132:101]),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .result(res)
    );

    // pad to whole bytes
    assign m_axis_tdata = {5'd0, res};

    // result stays put while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    // no new request while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && s_axis_tready))
        else $error("request taken while result pending");
    // an accepted request leaves ready low next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready && !m_axis_tvalid)
        else $error("controller did not start request");
endmodule
`default_nettype wire

>>> test/range_map_address_translator_tb.sv
`default_nettype none
module range_map_address_translator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rmat_pkg::*;

    localparam int DEPTH = 32;
    localparam logic [1:0] OP_OTHER = 2'd3;
    localparam logic [2:0] REG_BOGUS = 3'd7;

    typedef struct packed {
        logic [31:0] cell3;
        logic [31:0] cell2;
        logic [31:0] cell1;
        logic [31:0] cell0;
        logic [2:0]  arg_count;
        logic [1:0]  op;
    } request_t;

    typedef struct packed {
        logic [31:0] collision_total;
        logic [31:0] map_total;
        logic [31:0] translate_total;
        logic [1:0]  translate_source;
        logic [31:0] result_cell2;
        logic [31:0] result_cell1;
        logic        status;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [167:0] m_axis_tdata;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    range_map_address_translator i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // translator shadow state
    logic [31:0] win_ram_base, win_ram_size, win_rom_base, win_rom_size, shim_base;
    logic [31:0] tbl_virt [DEPTH];
    logic [31:0] tbl_phys [DEPTH];
    logic [31:0] tbl_size [DEPTH];
    logic [31:0] tbl_mode [DEPTH];
    int unsigned tbl_used;
    logic [31:0] n_translate, n_map, n_collide;

    request_t pending_requests[$];
    answer_t expected_answers[$];
    int errors = 0;
    int answers_seen = 0;
    bit hold_off = 1'b0;

    function automatic logic [31:0] clamp_end(logic [31:0] b, logic [31:0] s);
        logic [32:0] e;
        e = {1'b0, b} + {1'b0, s};
        return e[32] ? 32'hffffffff : e[31:0];
    endfunction

    function automatic bit covers(logic [31:0] a, logic [31:0] b, logic [31:0] s);
        return a >= b && a < clamp_end(b, s);
    endfunction

    function automatic bit shim_overlap(logic [31:0] b, logic [31:0] s);
        logic [32:0] hi;
        if (s == 0) s = 1;
        hi = {1'b0, shim_base} + 33'd4096;
        return {1'b0, b} < hi && clamp_end(b, s) > shim_base;
    endfunction

    // register write mirror
    function automatic void mirror_reg(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_RAM_BASE: begin win_ram_base = v; tbl_used = 0; end
            REG_RAM_SIZE: begin win_ram_size = v; tbl_used = 0; end
            REG_ROM_BASE: begin win_rom_base = v; tbl_used = 0; end
            REG_ROM_SIZE: begin win_rom_size = v; tbl_used = 0; end
            REG_SHIM_BASE: shim_base = v;
            default: ;
        endcase
    endfunction

    // translator behavior for one request
    function automatic answer_t translate_request(request_t r);
        answer_t a;
        logic [31:0] c0, c1, c2, c3;
        int n;
        bit found;
        n = r.arg_count;
        c0 = n >= 1 ? r.cell0 : 32'd0;
        c1 = n >= 2 ? r.cell1 : 32'd1;
        c2 = n >= 3 ? r.cell2 : 32'd0;
        c3 = n >= 4 ? r.cell3 : 32'd0;
        a = '0;
        a.translate_source = SRC_NONE;
        found = 0;
        case (r.op)
            OP_TRANSLATE:
            begin
                n_translate++;
                for (int i = int'(tbl_used) - 1; i >= 0 && !found; i--)
                    if (covers(c0, tbl_virt[i], tbl_size[i]))
                    begin
                        a.result_cell1 = tbl_phys[i] + (c0 - tbl_virt[i]);
                        a.result_cell2 = tbl_mode[i];
                        a.translate_source = SRC_MAP;
                        found = 1;
                    end
                if (!found)
                begin
                    if ((win_ram_size != 0 && c0 < win_ram_size) ||
                        (win_ram_size != 0 && covers(c0, win_ram_base, win_ram_size)) ||
                        (win_rom_size != 0 && covers(c0, win_rom_base, win_rom_size)))
                    begin
                        a.result_cell1 = c0;
                        a.result_cell2 = IDENTITY_MODE;
                        a.translate_source = SRC_IDENTITY;
                    end
                    else
                        a.translate_source = SRC_UNMAPPED;
                end
            end
            OP_CLAIM:
                if (shim_overlap(c0, c1))
                begin
                    n_collide++;
                    a.status = 1'b1;
                end
                else
                    a.result_cell1 = c0;
            OP_MAP:
            begin
                n_map++;
                if (shim_overlap(c2, c1))
                begin
                    n_collide++;
                    a.status = 1'b1;
                end
                else if (tbl_used < DEPTH)
                begin
                    tbl_virt[tbl_used] = c2;
                    tbl_phys[tbl_used] = c3;
                    tbl_size[tbl_used] = c1;
                    tbl_mode[tbl_used] = c0;
                    tbl_used++;
                end
            end
            default: ;
        endcase
        a.translate_total = n_translate;
        a.map_total = n_map;
        a.collision_total = n_collide;
        return a;
    endfunction

    // request driver
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            expected_answers.push_back(translate_request(request_t'(s_axis_tdata[132:0])));
            void'(pending_requests.pop_front());
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        end
        if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_requests.size() > 0 && rst_n)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {3'b000, pending_requests[0]};
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // answer monitor
    int recv_gap = 0;
    always @(posedge clk)
    begin
        answer_t got, exp_a;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = answer_t'(m_axis_tdata[162:0]);
            answers_seen++;
            if (expected_answers.size() == 0)
            begin
                $error("answer with no request outstanding");
                errors++;
            end
            else
            begin
                exp_a = expected_answers.pop_front();
                if (got.status !== exp_a.status)
                begin
                    $error("status exp %0h got %0h", exp_a.status, got.status);
                    errors++;
                end
                if (got.result_cell1 !== exp_a.result_cell1)
                begin
                    $error("result_cell1 exp %0h got %0h", exp_a.result_cell1, got.result_cell1);
                    errors++;
                end
                if (got.result_cell2 !== exp_a.result_cell2)
                begin
                    $error("result_cell2 exp %0h got %0h", exp_a.result_cell2, got.result_cell2);
                    errors++;
                end
                if (got.translate_source !== exp_a.translate_source)
                begin
                    $error("translate_source exp %0h got %0h", exp_a.translate_source,
                           got.translate_source);
                    errors++;
                end
                if (got.translate_total !== exp_a.translate_total)
                begin
                    $error("translate_total exp %0h got %0h", exp_a.translate_total,
                           got.translate_total);
                    errors++;
                end
                if (got.map_total !== exp_a.map_total)
                begin
                    $error("map_total exp %0h got %0h", exp_a.map_total, got.map_total);
                    errors++;
                end
                if (got.collision_total !== exp_a.collision_total)
                begin
                    $error("collision_total exp %0h got %0h", exp_a.collision_total,
                           got.collision_total);
                    errors++;
                end
            end
            recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        end
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // long receiver stall, counted in cycles
    initial
    begin
        repeat (300) @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    function automatic request_t make_req(logic [1:0] op, logic [2:0] n, logic [31:0] c0,
                                          logic [31:0] c1, logic [31:0] c2, logic [31:0] c3);
        request_t r;
        r.op = op;
        r.arg_count = n;
        r.cell0 = c0;
        r.cell1 = c1;
        r.cell2 = c2;
        r.cell3 = c3;
        return r;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hffffffff;
            2: return 32'hffffffff - $urandom_range(0, 8192);
            default: return $urandom();
        endcase
    endfunction

    // near an interesting address: windows, shim page, table entries
    function automatic logic [31:0] pick_addr(logic [31:0] a, logic [31:0] b, logic [31:0] s);
        case ($urandom_range(0, 6))
            0: return a;
            1: return b;
            2: return b + s - 1;
            3: return b + s;
            4: return b + $urandom_range(0, 255);
            5: return shim_base + $urandom_range(0, 4200) - 50;
            default: return $urandom();
        endcase
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        mirror_reg(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || expected_answers.size() > 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // one phase of random traffic, mostly map and translate
    task automatic random_phase(int count);
        logic [31:0] v, sz;
        int k;
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 3)
            begin
                sz = $urandom_range(0, 1) ? $urandom_range(0, 65536) : rand_word();
                v = $urandom_range(0, 1) ? shim_base + $urandom_range(0, 8000) - 4000
                                         : $urandom();
                pending_requests.push_back(make_req(OP_MAP, 3'($urandom_range(0, 7)),
                    $urandom(), sz, v, $urandom()));
            end
            else if (k < 8)
            begin
                if (tbl_used > 0 && $urandom_range(0, 1))
                begin
                    int e = $urandom_range(0, tbl_used - 1);
                    v = pick_addr(tbl_phys[e], tbl_virt[e], tbl_size[e]);
                end
                else
                    v = pick_addr(win_rom_base, win_ram_base, win_ram_size);
                pending_requests.push_back(make_req(OP_TRANSLATE,
                    $urandom_range(0, 3) == 0 ? 3'($urandom_range(0, 7)) : 3'd1,
                    v, $urandom(), $urandom(), $urandom()));
            end
            else if (k == 8)
                pending_requests.push_back(make_req(OP_CLAIM, 3'($urandom_range(0, 7)),
                    pick_addr(0, shim_base, 4096), rand_word(), $urandom(), $urandom()));
            else
                pending_requests.push_back(make_req(OP_OTHER, 3'($urandom_range(0, 7)),
                    rand_word(), rand_word(), rand_word(), rand_word()));
        end
        // tbl_used is advanced only by the prediction as requests are accepted; wait here
        drain();
    endtask

    // stimulus
    initial
    begin
        win_ram_base = 0; win_ram_size = 0; win_rom_base = 0; win_rom_size = 0;
        shim_base = 0; tbl_used = 0;
        n_translate = 0; n_map = 0; n_collide = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        write_reg(REG_RAM_BASE, 32'h1000_0000);
        write_reg(REG_RAM_SIZE, 32'h0100_0000);
        write_reg(REG_ROM_BASE, 32'hfff0_0000);
        write_reg(REG_ROM_SIZE, 32'h0020_0000);
        write_reg(REG_SHIM_BASE, 32'h6800_0000);
        write_reg(REG_BOGUS, 32'hdead_beef);

        // directed: defaults, apertures, wrap clamp, zero size, collisions
        pending_requests.push_back(make_req(OP_TRANSLATE, 0, 32'h5, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 1, 32'h00ff_ffff, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 1, 32'h1000_0000, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 1, 32'hffff_fffe, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 1, 32'hffff_ffff, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 4, 32'h2000_0000, '1, '1, '1));
        pending_requests.push_back(make_req(OP_CLAIM, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_req(OP_CLAIM, 2, 32'h6800_0fff, 0, 0, 0));
        pending_requests.push_back(make_req(OP_CLAIM, 2, 32'h67ff_ffff, 1, 0, 0));
        pending_requests.push_back(make_req(OP_CLAIM, 7, 32'h6800_1000, '1, '1, '1));
        pending_requests.push_back(make_req(OP_MAP, 4, 32'h33, 32'h1000, 32'h4000_0000,
                                            32'h0000_8000));
        pending_requests.push_back(make_req(OP_MAP, 4, 32'h44, 32'h100, 32'h4000_0080,
                                            32'h0009_0000));
        pending_requests.push_back(make_req(OP_MAP, 4, 32'h55, 0, 32'h5000_0000, 32'h1));
        pending_requests.push_back(make_req(OP_MAP, 4, 32'h66, '1, 32'hf000_0000, 32'h2));
        pending_requests.push_back(make_req(OP_MAP, 4, 32'h77, 32'h10, 32'h6800_0800, 0));
        pending_requests.push_back(make_req(OP_MAP, 0, 0, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 1, 32'h4000_0090, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 1, 32'h4000_0fff, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 1, 32'h5000_0000, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 1, 32'hffff_fffe, 0, 0, 0));
        pending_requests.push_back(make_req(OP_TRANSLATE, 1, 32'hffff_ffff, 0, 0, 0));
        pending_requests.push_back(make_req(OP_OTHER, 7, '1, '1, '1, '1));
        drain();

        // fill the table past its depth, then shim at the top of memory
        for (int i = 0; i < 40; i++)
            pending_requests.push_back(make_req(OP_MAP, 4, i, 32'h100,
                32'h2000_0000 + i * 32'h80, 32'h0100_0000 * i));
        drain();
        random_phase(100);

        write_reg(REG_SHIM_BASE, 32'hffff_f800);
        write_reg(REG_RAM_SIZE, 32'hffff_ffff);
        write_reg(REG_RAM_BASE, 32'hffff_ffff);
        random_phase(150);

        write_reg(REG_RAM_SIZE, 0);
        write_reg(REG_ROM_SIZE, 0);
        write_reg(REG_SHIM_BASE, 0);
        random_phase(150);

        write_reg(REG_RAM_BASE, $urandom());
        write_reg(REG_RAM_SIZE, $urandom());
        write_reg(REG_ROM_BASE, $urandom());
        write_reg(REG_ROM_SIZE, $urandom());
        write_reg(REG_SHIM_BASE, $urandom());
        random_phase(250);

        write_reg(REG_ROM_BASE, 32'hffff_ffff);
        write_reg(REG_ROM_SIZE, 32'hffff_ffff);
        write_reg(REG_SHIM_BASE, 32'hffff_ffff);
        random_phase(240);

        $display("covered %0d answers: translate %0d, map %0d, reserved-page hits %0d",
                 answers_seen, n_translate, n_map, n_collide);
        if (errors == 0 && expected_answers.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> range_map_address_translator.f
rtl/core/rmat_pkg.sv
rtl/core/rmat_ram.sv
rtl/core/rmat_ctrl.sv
rtl/core/rmat_dp.sv
rtl/core/range_map_address_translator.sv
test/range_map_address_translator_tb.sv
